### rtl/slice_shift_table_generator_core_defines.svh
// Assertion macros shared by the slice shift table generator.
// Each macro is empty when SYNTHESIS is defined.
`ifndef SLICE_SHIFT_TABLE_GENERATOR_CORE_DEFINES_SVH
`define SLICE_SHIFT_TABLE_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define SSG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define SSG_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`else

`define SSG_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSG_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg)

`endif

`endif

### rtl/ssg_pkg.sv
`default_nettype none

package ssg_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_SEED       = 2'd0;
    localparam logic [1:0] REG_SLICE      = 2'd1;
    localparam logic [1:0] REG_SMOOTH     = 2'd2;
    localparam int         CFG_IDX_W      = 2;
    localparam int         CFG_DATA_W     = 32;

    // Hash and seed constants.
    localparam logic [31:0] HASH_MUL_A    = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B    = 32'h846ca68b;
    localparam logic [31:0] HASH_ZERO_ALT = 32'h6d2b79f5;
    localparam logic [31:0] HASH_GOLDEN   = 32'h9e3779b9;
    localparam logic [31:0] SEED_DEFAULT  = 32'h1234abcd;

    // Clamping limits and the base run length.
    localparam logic [7:0] SLICE_MIN      = 8'd2;
    localparam logic [7:0] SLICE_MAX      = 8'd128;
    localparam logic [6:0] SMOOTH_MAX     = 7'd90;
    localparam logic [6:0] HALF_MIN       = 7'd2;
    localparam logic [7:0] RUN_BASE       = 8'd4;

    // Blend arithmetic: percentages, rounding term and the reciprocal of 100.
    localparam logic [6:0]  PCT_FULL      = 7'd100;
    localparam logic [15:0] BLEND_ROUND   = 16'd50;
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int          RECIP_SHIFT   = 19;

    // Remainder unit: bits retired per cycle and cycle count for 32 bits.
    localparam int MOD_STEP   = 4;
    localparam int MOD_CYCLES = 32 / MOD_STEP;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    // Request to and response from the draw unit.
    typedef struct packed {
        logic        start;
        logic [31:0] state;
        logic [7:0]  div;
    } t_draw_req;

    typedef struct packed {
        logic        done;
        logic [31:0] state;
        logic [7:0]  rem;
    } t_draw_rsp;

endpackage

`default_nettype wire

### rtl/ssg_in_if.sv
`default_nettype none

interface ssg_in_if;
    logic        valid;
    logic        ready;
    logic        axis;
    logic [10:0] position;
    logic        first_of_table;
    logic        last_of_table;

    modport source (
        output valid, axis, position, first_of_table, last_of_table,
        input  ready
    );

    modport sink (
        input  valid, axis, position, first_of_table, last_of_table,
        output ready
    );
endinterface

`default_nettype wire

### rtl/ssg_out_if.sv
`default_nettype none

interface ssg_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] shift_out;
    logic [10:0]       position_out;

    modport source (
        output valid, shift_out, position_out,
        input  ready
    );

    modport sink (
        input  valid, shift_out, position_out,
        output ready
    );
endinterface

`default_nettype wire

### rtl/slice_shift_table_generator_core.sv
// Channel   | Dir | Handshake    | Payload
// i_item    | in  | valid/ready  | axis, position, first_of_table, last_of_table
// o_result  | out | valid/ready  | shift_out, position_out
// i_cfg_*   | in  | write enable | register index, 32-bit data
//
// An item whose run continues goes from acceptance through the multiply, sum and scale
// states to a loaded result; when the run expires it first takes two draws, each through the
// draw unit (two 32-bit multiply stages and a 4-bit-per-cycle remainder loop).
// One item is worked on at a time; the next is taken once the result has been loaded.
// A result waiting in the output register does not hold back the next item, only
// the load of its own result. Reset is synchronous and needs no clearing pass.

`default_nettype none

`include "slice_shift_table_generator_core_defines.svh"

module slice_shift_table_generator_core
    import ssg_pkg::*;
#(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ssg_in_if.sink                     i_item,
    ssg_out_if.source                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW_SHIFT,
        S_DRAW_RUN,
        S_MUL,
        S_SUM,
        S_SCALE,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [31:0] r_seed;
    logic [7:0]  r_slice;
    logic [6:0]  r_smooth;

    // Generator state.
    logic [31:0]       r_prng;
    logic [6:0]        r_run_left;
    logic signed [7:0] r_cur_shift;
    logic              r_tbl_present;
    logic [6:0]        r_keep;
    logic              r_draw_start;

    // Item under work and blend pipeline.
    logic               r_axis;
    logic [10:0]        r_pos;
    logic               r_last;
    logic               r_in_table;
    logic signed [15:0] r_p1;
    logic signed [15:0] r_p2;
    logic signed [15:0] r_num;
    logic               r_neg;
    logic [27:0]        r_q;

    // Output register.
    logic              r_out_valid;
    logic signed [7:0] r_out_shift;
    logic [10:0]       r_out_pos;

    t_draw_req w_req;
    t_draw_rsp w_rsp;

    logic              w_accept;
    logic              w_out_free;
    logic              w_finish;
    logic [7:0]        w_cnt;
    logic [6:0]        w_half;
    logic [6:0]        w_half_run;
    logic [7:0]        w_div_shift;
    logic [7:0]        w_div_run;
    logic [6:0]        w_smooth_c;
    logic [31:0]       w_seed_eff;
    logic [31:0]       w_pos32;
    logic [31:0]       w_rpos32;
    logic              w_in_table;
    logic              w_first_col;
    logic [6:0]        w_run_eff;
    logic [6:0]        w_take;
    logic [7:0]        w_col_rdata;
    logic [7:0]        w_row_rdata;
    logic signed [7:0] w_prev;
    logic signed [15:0] w_cur_ext;
    logic signed [15:0] w_take_ext;
    logic signed [15:0] w_prev_ext;
    logic signed [15:0] w_keep_ext;
    logic [14:0]       w_abs;
    logic [8:0]        w_qv;
    logic [7:0]        w_v;

    // Clamped slice count, half range, the two draw divisors, clamped smoothing and effective seed.
    always_comb begin
        if (r_slice < SLICE_MIN) begin
            w_cnt = SLICE_MIN;
        end else if (r_slice > SLICE_MAX) begin
            w_cnt = SLICE_MAX;
        end else begin
            w_cnt = r_slice;
        end
        w_half      = w_cnt[7:1];
        w_half_run  = (w_half > HALF_MIN) ? w_half : HALF_MIN;
        w_div_shift = {w_half, 1'b1};
        w_div_run   = {1'b0, w_half_run} + 8'd1;
        w_smooth_c  = (r_smooth > SMOOTH_MAX) ? SMOOTH_MAX : r_smooth;
        w_seed_eff  = (r_seed == 32'd0) ? SEED_DEFAULT : r_seed;
    end

    // Input handshake and table range check.
    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && (r_state == S_IDLE);
    assign w_pos32      = 32'(i_item.position);
    assign w_rpos32     = 32'(r_pos);
    assign w_in_table   = i_item.axis ? (w_pos32 < 32'(MAX_ROWS))
                                      : (w_pos32 < 32'(MAX_COLUMNS));
    assign w_first_col  = i_item.first_of_table && !i_item.axis;
    assign w_run_eff    = i_item.first_of_table ? 7'd0 : r_run_left;

    // Output register is free when empty or being emptied this cycle.
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_finish   = (r_state == S_FINISH) && w_out_free;

    // Draw unit request.
    assign w_req.start = r_draw_start;
    assign w_req.state = r_prng;
    assign w_req.div   = (r_state == S_DRAW_SHIFT) ? w_div_shift : w_div_run;

    ssg_draw u_draw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Blend operands: new shift weighted by take, previous entry by keep.
    // The previous entry is left out altogether when none of it is kept.
    always_comb begin
        w_take     = PCT_FULL - r_keep;
        w_prev     = (r_in_table && (r_keep != 7'd0)) ?
                     (r_axis ? w_row_rdata : w_col_rdata) : 8'sd0;
        w_cur_ext  = {{8{r_cur_shift[7]}}, r_cur_shift};
        w_take_ext = {9'd0, w_take};
        w_prev_ext = {{8{w_prev[7]}}, w_prev};
        w_keep_ext = {9'd0, r_keep};
        w_abs      = r_num[15] ? 15'(-r_num) : r_num[14:0];
        w_qv       = r_q[RECIP_SHIFT +: 9];
        w_v        = r_neg ? 8'(-w_qv) : w_qv[7:0];
    end

    // Shift tables: read at acceptance, written back when the result is loaded.
    ssg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_COLUMNS)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_finish && r_in_table && !r_axis),
        .i_waddr (w_rpos32[COL_AW-1:0]),
        .i_wdata (w_v),
        .i_re    (w_accept && w_in_table && !i_item.axis),
        .i_raddr (w_pos32[COL_AW-1:0]),
        .o_rdata (w_col_rdata)
    );

    ssg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_finish && r_in_table && r_axis),
        .i_waddr (w_rpos32[ROW_AW-1:0]),
        .i_wdata (w_v),
        .i_re    (w_accept && w_in_table && i_item.axis),
        .i_raddr (w_pos32[ROW_AW-1:0]),
        .o_rdata (w_row_rdata)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_run_eff == 7'd0) ? S_DRAW_SHIFT : S_MUL;
                end
            end
            S_DRAW_SHIFT: begin
                if (w_rsp.done) begin
                    n_state = S_DRAW_RUN;
                end
            end
            S_DRAW_RUN: begin
                if (w_rsp.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_SUM;
            S_SUM:    n_state = S_SCALE;
            S_SCALE:  n_state = S_FINISH;
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // State, configuration, generator state, item and blend registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_seed        <= '0;
            r_slice       <= 8'd63;
            r_smooth      <= '0;
            r_prng        <= '0;
            r_run_left    <= '0;
            r_cur_shift   <= '0;
            r_tbl_present <= 1'b0;
            r_keep        <= '0;
            r_draw_start  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_draw_start <= 1'b0;

            // Register writes; an index beyond the list is ignored.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SEED:   r_seed   <= i_cfg_data;
                    REG_SLICE:  r_slice  <= i_cfg_data[7:0];
                    REG_SMOOTH: r_smooth <= i_cfg_data[6:0];
                    default:    ;
                endcase
            end

            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_axis     <= i_item.axis;
                        r_pos      <= i_item.position;
                        r_last     <= i_item.last_of_table;
                        r_in_table <= w_in_table;
                        if (w_first_col) begin
                            r_prng <= w_seed_eff;
                            r_keep <= r_tbl_present ? w_smooth_c : 7'd0;
                        end
                        if (i_item.first_of_table) begin
                            r_cur_shift <= '0;
                        end
                        if (w_run_eff == 7'd0) begin
                            r_run_left   <= '0;
                            r_draw_start <= 1'b1;
                        end else begin
                            r_run_left <= w_run_eff - 7'd1;
                        end
                    end
                end
                S_DRAW_SHIFT: begin
                    if (w_rsp.done) begin
                        r_prng       <= w_rsp.state;
                        r_cur_shift  <= w_rsp.rem - {1'b0, w_half};
                        r_draw_start <= 1'b1;
                    end
                end
                S_DRAW_RUN: begin
                    if (w_rsp.done) begin
                        r_prng     <= w_rsp.state;
                        r_run_left <= 7'(w_rsp.rem + RUN_BASE);
                    end
                end
                S_MUL: begin
                    r_p1 <= w_cur_ext * w_take_ext;
                    r_p2 <= w_prev_ext * w_keep_ext;
                end
                S_SUM: begin
                    r_num <= r_p1 + r_p2 + BLEND_ROUND;
                end
                S_SCALE: begin
                    r_neg <= r_num[15];
                    r_q   <= {13'd0, w_abs} * {15'd0, RECIP_100};
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_shift <= w_v;
                        r_out_pos   <= r_pos;
                        if (r_axis && r_last) begin
                            r_tbl_present <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.shift_out    = r_out_shift;
    assign o_result.position_out = r_out_pos;

    `SSG_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_accept, !i_item.ready, "second item taken while one is at work")
    `SSG_ASSERT(a_run_range, i_clk, i_rst_n, r_run_left <= 7'd68, "run length out of range")
    `SSG_ASSERT(a_shift_range, i_clk, i_rst_n, (r_cur_shift >= -8'sd64) && (r_cur_shift <= 8'sd64), "shift out of range")

endmodule

`default_nettype wire

### rtl/ssg_ram.sv
`default_nettype none

module ssg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/ssg_draw.sv
`default_nettype none

`include "slice_shift_table_generator_core_defines.svh"

module ssg_draw
    import ssg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_draw_req i_req,
    output t_draw_rsp      o_rsp
);

    typedef enum logic [2:0] {
        D_IDLE,
        D_MIX2,
        D_MIX3,
        D_MOD
    } t_dstate;

    t_dstate               r_state;
    logic                  r_done;
    logic [31:0]           r_mix;
    logic [31:0]           r_hash;
    logic [31:0]           r_dvd;
    logic [7:0]            r_rem;
    logic [7:0]            r_div;
    logic [MOD_CNT_W-1:0]  r_cnt;

    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [31:0] w_z;
    logic [7:0]  w_rem_n;
    logic [8:0]  w_t;

    // Hash folds; round one adds the increment and folds the top half down.
    always_comb begin
        w_x = i_req.state + HASH_GOLDEN;
        w_x = w_x ^ (w_x >> 16);
        w_y = r_mix ^ (r_mix >> 15);
        w_z = r_mix ^ (r_mix >> 16);
    end

    // Restoring remainder, several dividend bits per cycle from the top.
    always_comb begin
        w_rem_n = r_rem;
        w_t     = '0;
        for (int k = 0; k < MOD_STEP; k++) begin
            w_t = {w_rem_n, r_dvd[31-k]};
            if (w_t >= {1'b0, r_div}) begin
                w_t = w_t - {1'b0, r_div};
            end
            w_rem_n = w_t[7:0];
        end
    end

    // Sequencer: three hash stages, then the remainder loop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_mix   <= w_x * HASH_MUL_A;
                        r_div   <= i_req.div;
                        r_state <= D_MIX2;
                    end
                end
                D_MIX2: begin
                    r_mix   <= w_y * HASH_MUL_B;
                    r_state <= D_MIX3;
                end
                D_MIX3: begin
                    r_hash  <= (w_z == 32'd0) ? HASH_ZERO_ALT : w_z;
                    r_dvd   <= (w_z == 32'd0) ? HASH_ZERO_ALT : w_z;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= D_MOD;
                end
                D_MOD: begin
                    r_rem <= w_rem_n;
                    r_dvd <= r_dvd << MOD_STEP;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MOD_CNT_W'(MOD_CYCLES - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.state = r_hash;
    assign o_rsp.rem   = r_rem;

    `SSG_ASSERT(a_div_nonzero, i_clk, i_rst_n, !(i_req.start && i_req.div == 8'd0), "draw started with a zero divisor")
    `SSG_ASSERT(a_start_idle, i_clk, i_rst_n, !i_req.start || r_state == D_IDLE, "draw started while busy")
    `SSG_ASSERT(a_rem_below, i_clk, i_rst_n, !r_done || r_rem < r_div, "remainder not below divisor")

endmodule

`default_nettype wire
